/* design/fbd_pkg.sv */
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared widths and constants for the fractional baud divisor search.
// ----------------------------------------------------------------------------
package fbd_pkg;

  localparam int CLK_W      = 27;
  localparam int BAUD_W     = 22;
  localparam int DIV_W      = 17;
  localparam int FRAC_W     = 4;
  localparam int SUM_W      = 5;
  localparam int ERR_W      = 32;
  localparam int FRAC_SHIFT = 28;

  // Dividend: (clock << 28) * mul, divisor: baud * (mul + divadd)
  localparam int NUM_W = CLK_W + FRAC_SHIFT + FRAC_W;
  localparam int DEN_W = BAUD_W + SUM_W;
  localparam int DVR_W = NUM_W - ERR_W;

  localparam logic [CLK_W-1:0]  CLK_RESET  = CLK_W'(25000000);
  localparam logic [DIV_W-1:0]  DIV_MAX    = DIV_W'(65536);
  localparam logic [FRAC_W-1:0] MUL_MAX    = FRAC_W'(15);
  localparam logic [6:0]        PCT_SCALE  = 7'd100;
  localparam logic [ERR_W-1:0]  ERR_WORST  = 32'hFFFF_FFFF;
  localparam logic [ERR_W-1:0]  ERR_HALF   = 32'h8000_0000;

endpackage

/* design/fbd_div.sv */
// ----------------------------------------------------------------------------
// fbd_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbd_div
  import fbd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             run_r,  run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [NUM_W-1:0] acc_r,  acc_nxt;
  logic [DEN_W-1:0] rem_r,  rem_nxt;
  logic [DEN_W-1:0] den_r,  den_nxt;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  always_comb begin
    trial = {rem_r, acc_r[NUM_W-1]};
    diff  = trial - {1'b0, den_r};
    fits  = trial >= {1'b0, den_r};

    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;

    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
    end else if (run_r) begin
      acc_nxt = {acc_r[NUM_W-2:0], fits};
      rem_nxt = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(NUM_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quot = acc_r;

endmodule

/* design/fractional_baud_divisor_search.sv */
// ----------------------------------------------------------------------------
// fractional_baud_divisor_search
// Searches fractional (mul, divadd) pairs for the best UART baud divisor.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en / cfg_wr_data write the peripheral clock in Hz (reset value
//   25 MHz); write it only while busy is low.
//   A transaction is taken when start is high and busy is low; in_baud_rate
//   is sampled then. busy stays high until the result is out.
//   The result appears for one cycle with out_valid; there is no back
//   pressure, so the receiver must capture it in that cycle.
//   Each candidate pair takes one run of the shared 59-bit
//   one-bit-per-cycle divider; up to 120 pairs are tried, then, if a valid
//   divisor was found, one more division recalculates the baud. The search
//   stops early when an exact divisor is hit. A zero baud rate skips the
//   search and returns a failed result from the judge state.
//   One transaction is in flight at a time; a new one may start in the
//   cycle the result is shown.
//   Reset returns to idle with the clock register at its reset value.
// ----------------------------------------------------------------------------
module fractional_baud_divisor_search
  import fbd_pkg::*;
#(
  parameter int MAX_ERROR_PCT = 3
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CLK_W-1:0]  cfg_wr_data,
  input  logic              start,
  output logic              busy,
  input  logic [BAUD_W-1:0] in_baud_rate,
  output logic              out_valid,
  output logic [DIV_W-1:0]  out_integer_divisor,
  output logic [FRAC_W-1:0] out_frac_divadd,
  output logic [FRAC_W-1:0] out_frac_mul,
  output logic              out_found_ok
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PREP     = 4'd1;
  localparam logic [3:0] ST_START    = 4'd2;
  localparam logic [3:0] ST_WAIT     = 4'd3;
  localparam logic [3:0] ST_EVAL     = 4'd4;
  localparam logic [3:0] ST_RC_PREP  = 4'd5;
  localparam logic [3:0] ST_RC_START = 4'd6;
  localparam logic [3:0] ST_RC_WAIT  = 4'd7;
  localparam logic [3:0] ST_DIFF     = 4'd8;
  localparam logic [3:0] ST_JUDGE    = 4'd9;

  localparam logic [6:0] MAX_PCT = 7'(MAX_ERROR_PCT);
  localparam int         LHS_W   = CLK_W + 7;

  logic [3:0]        state_r, state_nxt;
  logic [CLK_W-1:0]  clk_cfg_r;
  logic [BAUD_W-1:0] baud_r, baud_nxt;
  logic [FRAC_W-1:0] mul_r, mul_nxt;
  logic [FRAC_W-1:0] add_r, add_nxt;
  logic [ERR_W-1:0]  best_err_r, best_err_nxt;
  logic [DIV_W-1:0]  best_div_r, best_div_nxt;
  logic [FRAC_W-1:0] best_mul_r, best_mul_nxt;
  logic [FRAC_W-1:0] best_add_r, best_add_nxt;
  logic              found_r, found_nxt;
  logic [NUM_W-1:0]  dnum_r, dnum_nxt;
  logic [DEN_W-1:0]  dden_r, dden_nxt;
  logic [CLK_W-1:0]  diff_r, diff_nxt;

  logic              ov_r, ov_nxt;
  logic [DIV_W-1:0]  o_div_r, o_div_nxt;
  logic [FRAC_W-1:0] o_add_r, o_add_nxt;
  logic [FRAC_W-1:0] o_mul_r, o_mul_nxt;
  logic              o_ok_r, o_ok_nxt;

  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;

  logic [SUM_W-1:0]  pair_sum;
  logic [SUM_W-1:0]  best_sum;
  logic [ERR_W-1:0]  err_raw;
  logic              round_up;
  logic [ERR_W-1:0]  err;
  logic [DVR_W:0]    dv;
  logic              in_range;
  logic              win;
  logic              last_pair;
  logic [CLK_W-1:0]  recalc;
  logic [LHS_W-1:0]  lhs;
  logic [LHS_W-1:0]  rhs;

  fbd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dnum_r),
    .den   (dden_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign div_start = (state_r == ST_START) || (state_r == ST_RC_START);

  always_comb begin
    pair_sum  = {1'b0, mul_r} + {1'b0, add_r};
    best_sum  = {1'b0, best_mul_r} + {1'b0, best_add_r};
    err_raw   = div_quot[ERR_W-1:0];
    round_up  = err_raw > ERR_HALF;
    err       = round_up ? (~err_raw + ERR_W'(1)) : err_raw;
    dv        = {1'b0, div_quot[NUM_W-1:ERR_W]} + (DVR_W+1)'(round_up);
    in_range  = (dv != '0) && (dv <= (DVR_W+1)'(DIV_MAX));
    win       = in_range && (err < best_err_r);
    last_pair = (mul_r == MUL_MAX) && (add_r == mul_r - FRAC_W'(1));
    recalc    = div_quot[CLK_W-1:0];
    lhs       = LHS_W'(diff_r) * LHS_W'(PCT_SCALE);
    rhs       = LHS_W'(baud_r) * LHS_W'(MAX_PCT);
  end

  always_comb begin
    state_nxt    = state_r;
    baud_nxt     = baud_r;
    mul_nxt      = mul_r;
    add_nxt      = add_r;
    best_err_nxt = best_err_r;
    best_div_nxt = best_div_r;
    best_mul_nxt = best_mul_r;
    best_add_nxt = best_add_r;
    found_nxt    = found_r;
    dnum_nxt     = dnum_r;
    dden_nxt     = dden_r;
    diff_nxt     = diff_r;
    ov_nxt       = 1'b0;
    o_div_nxt    = o_div_r;
    o_add_nxt    = o_add_r;
    o_mul_nxt    = o_mul_r;
    o_ok_nxt     = o_ok_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          baud_nxt     = in_baud_rate;
          mul_nxt      = FRAC_W'(1);
          add_nxt      = '0;
          best_err_nxt = ERR_WORST;
          found_nxt    = 1'b0;
          state_nxt    = (in_baud_rate == '0) ? ST_JUDGE : ST_PREP;
        end
      end
      ST_PREP: begin
        dnum_nxt  = {(CLK_W+FRAC_W)'(clk_cfg_r) * (CLK_W+FRAC_W)'(mul_r),
                     FRAC_SHIFT'(0)};
        dden_nxt  = DEN_W'(baud_r) * DEN_W'(pair_sum);
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_done) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (win) begin
          best_err_nxt = err;
          best_div_nxt = dv[DIV_W-1:0];
          best_mul_nxt = mul_r;
          best_add_nxt = add_r;
          found_nxt    = 1'b1;
        end
        if (add_r == mul_r - FRAC_W'(1)) begin
          mul_nxt = mul_r + FRAC_W'(1);
          add_nxt = '0;
        end else begin
          add_nxt = add_r + FRAC_W'(1);
        end
        if ((win && err == '0) || last_pair) begin
          state_nxt = found_nxt ? ST_RC_PREP : ST_JUDGE;
        end else begin
          state_nxt = ST_PREP;
        end
      end
      ST_RC_PREP: begin
        dnum_nxt  = NUM_W'(CLK_W'(clk_cfg_r[CLK_W-1:4]) * CLK_W'(best_mul_r));
        dden_nxt  = DEN_W'(best_div_r) * DEN_W'(best_sum);
        state_nxt = ST_RC_START;
      end
      ST_RC_START: begin
        state_nxt = ST_RC_WAIT;
      end
      ST_RC_WAIT: begin
        if (div_done) begin
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: begin
        diff_nxt  = (CLK_W'(baud_r) > recalc) ? (CLK_W'(baud_r) - recalc)
                                              : (recalc - CLK_W'(baud_r));
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        ov_nxt    = 1'b1;
        o_ok_nxt  = found_r && (lhs < rhs);
        o_div_nxt = o_ok_nxt ? best_div_r : '0;
        o_add_nxt = o_ok_nxt ? best_add_r : '0;
        o_mul_nxt = o_ok_nxt ? best_mul_r : '0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      clk_cfg_r <= CLK_RESET;
      ov_r      <= 1'b0;
      found_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      found_r <= found_nxt;
      if (cfg_wr_en) begin
        clk_cfg_r <= cfg_wr_data;
      end
    end
    baud_r     <= baud_nxt;
    mul_r      <= mul_nxt;
    add_r      <= add_nxt;
    best_err_r <= best_err_nxt;
    best_div_r <= best_div_nxt;
    best_mul_r <= best_mul_nxt;
    best_add_r <= best_add_nxt;
    dnum_r     <= dnum_nxt;
    dden_r     <= dden_nxt;
    diff_r     <= diff_nxt;
    o_div_r    <= o_div_nxt;
    o_add_r    <= o_add_nxt;
    o_mul_r    <= o_mul_nxt;
    o_ok_r     <= o_ok_nxt;
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = ov_r;
  assign out_integer_divisor = o_div_r;
  assign out_frac_divadd     = o_add_r;
  assign out_frac_mul        = o_mul_r;
  assign out_found_ok        = o_ok_r;

endmodule

/* sim/tb_fractional_baud_divisor_search.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fractional_baud_divisor_search
// Drives baud rate requests under several peripheral clock settings, predicts
// the chosen divisor, mul and divadd for each transaction, and checks every
// result strobe against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_fractional_baud_divisor_search
  import fbd_pkg::*;
();

  localparam int MAX_ERROR_PCT = 3;
  localparam int CYCLE_LIMIT   = 5_000_000;

  typedef struct packed {
    logic [DIV_W-1:0]  divisor;
    logic [FRAC_W-1:0] divadd;
    logic [FRAC_W-1:0] mul;
    logic              ok;
  } divisor_choice_t;

  logic              clk;
  logic              rst_n        = 1'b0;
  logic              cfg_wr_en    = 1'b0;
  logic [CLK_W-1:0]  cfg_wr_data  = '0;
  logic              start        = 1'b0;
  logic [BAUD_W-1:0] in_baud_rate = '0;
  logic              busy;
  logic              out_valid;
  logic [DIV_W-1:0]  out_integer_divisor;
  logic [FRAC_W-1:0] out_frac_divadd;
  logic [FRAC_W-1:0] out_frac_mul;
  logic              out_found_ok;

  divisor_choice_t   pending_choices[$];
  logic [CLK_W-1:0]  clock_hz       = CLK_RESET;
  int                mismatch_count = 0;
  int                burst_left     = 0;
  int                cycle_count    = 0;

  fractional_baud_divisor_search #(.MAX_ERROR_PCT(MAX_ERROR_PCT)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .start               (start),
    .busy                (busy),
    .in_baud_rate        (in_baud_rate),
    .out_valid           (out_valid),
    .out_integer_divisor (out_integer_divisor),
    .out_frac_divadd     (out_frac_divadd),
    .out_frac_mul        (out_frac_mul),
    .out_found_ok        (out_found_ok)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic divisor_choice_t search_divisor(input logic [BAUD_W-1:0] baud,
                                                     input logic [CLK_W-1:0]  clk_in);
    divisor_choice_t   choice;
    logic [63:0]       num, den, q, err, dv, recalc, diff, pct;
    logic [63:0]       best_err, best_div;
    logic [FRAC_W-1:0] best_mul, best_add;
    logic              found, exact;
    choice   = '0;
    best_err = 64'hFFFF_FFFF;
    best_div = '0;
    best_mul = '0;
    best_add = '0;
    found    = 1'b0;
    exact    = 1'b0;
    if (baud != '0) begin
      for (int m = 1; m <= 15 && !exact; m++) begin
        for (int a = 0; a < m && !exact; a++) begin
          num = (64'(clk_in) << FRAC_SHIFT) * 64'(m);
          den = 64'(baud) * 64'(m + a);
          q   = num / den;
          err = {32'd0, q[31:0]};
          dv  = {32'd0, q[63:32]};
          // above one half: round the divisor up, error measured from above
          if (err > 64'h8000_0000) begin
            err = 64'h1_0000_0000 - err;
            dv  = dv + 64'd1;
          end
          if (dv >= 64'd1 && dv <= 64'(DIV_MAX) && err < best_err) begin
            best_err = err;
            best_div = dv;
            best_mul = FRAC_W'(m);
            best_add = FRAC_W'(a);
            found    = 1'b1;
            exact    = (err == 64'd0);
          end
        end
      end
      if (found) begin
        recalc = (64'(clk_in >> 4) * 64'(best_mul))
               / (best_div * (64'(best_mul) + 64'(best_add)));
        diff   = (64'(baud) > recalc) ? 64'(baud) - recalc : recalc - 64'(baud);
        pct    = diff * 64'd100 / 64'(baud);
        if (pct < 64'(MAX_ERROR_PCT)) begin
          choice.divisor = best_div[DIV_W-1:0];
          choice.divadd  = best_add;
          choice.mul     = best_mul;
          choice.ok      = 1'b1;
        end
      end
    end
    return choice;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR @%0t %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    divisor_choice_t want;
    if (rst_n && out_valid) begin
      if (pending_choices.size() == 0) begin
        report_mismatch("result with no transaction outstanding", 1, 0);
      end else begin
        want = pending_choices.pop_front();
        if (out_integer_divisor !== want.divisor)
          report_mismatch("integer_divisor", out_integer_divisor, want.divisor);
        if (out_frac_divadd !== want.divadd)
          report_mismatch("frac_divadd", out_frac_divadd, want.divadd);
        if (out_frac_mul !== want.mul)
          report_mismatch("frac_mul", out_frac_mul, want.mul);
        if (out_found_ok !== want.ok)
          report_mismatch("found_ok", out_found_ok, want.ok);
      end
    end
  end

  // start stays high across a burst; a gap is taken before each new burst
  task automatic send_baud(input logic [BAUD_W-1:0] baud);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 6);
    end
    burst_left--;
    start        <= 1'b1;
    in_baud_rate <= baud;
    do @(posedge clk); while (busy !== 1'b0);
    pending_choices.push_back(search_divisor(baud, clock_hz));
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hz;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    clock_hz = hz;
  endtask

  function automatic logic [BAUD_W-1:0] pick_baud();
    int rates[16] = '{300, 1200, 2400, 4800, 9600, 19200, 38400, 57600, 115200,
                      230400, 460800, 921600, 1000000, 2000000, 3000000, 4000000};
    int r, d;
    case ($urandom_range(0, 9))
      0, 1:    return BAUD_W'($urandom_range(0, 22'h3F_FFFF));
      2:       return BAUD_W'($urandom_range(1, 300));
      default: begin
        r = rates[$urandom_range(0, 15)];
        d = r / 50;
        return BAUD_W'(r - d + $urandom_range(0, 2 * d));
      end
    endcase
  endfunction

  function automatic logic [CLK_W-1:0] pick_clock();
    int clocks[8] = '{1843200, 12000000, 14745600, 18432000, 25000000, 48000000,
                      72000000, 100000000};
    case ($urandom_range(0, 5))
      0:       return CLK_W'($urandom_range(1, 100000000));
      1:       return CLK_W'($urandom_range(0, 27'h7FF_FFFF));
      default: return CLK_W'(clocks[$urandom_range(0, 7)]);
    endcase
  endfunction

  task automatic test_reset_clock();
    send_baud(22'd9600);
    send_baud(22'd115200);
    send_baud(22'd1);
    send_baud(22'd4000000);
    send_baud(22'h3F_FFFF);
  endtask

  task automatic test_zero_baud();
    send_baud('0);
    send_baud(22'd9600);
  endtask

  task automatic test_exact_divisors();
    write_clock(27'd1843200);
    send_baud(22'd115200);
    send_baud(22'd9600);
    send_baud(22'd300);
    send_baud(22'd1);
  endtask

  task automatic test_clock_extremes();
    write_clock('0);
    send_baud(22'd9600);
    send_baud('0);
    write_clock(27'd1);
    send_baud(22'd1);
    write_clock(27'h7FF_FFFF);
    send_baud(22'd1);
    send_baud(22'd4000000);
    send_baud(22'h3F_FFFF);
    write_clock(27'd100000000);
    send_baud(22'd115200);
    send_baud(22'd4000000);
    send_baud(22'd300);
  endtask

  task automatic test_random_requests();
    for (int p = 0; p < 4; p++) begin
      write_clock(pick_clock());
      for (int i = 0; i < 20; i++) send_baud(pick_baud());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_clock();
    test_zero_baud();
    test_exact_divisors();
    test_clock_extremes();
    test_random_requests();
    wait_idle();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* fractional_baud_divisor_search.f */
design/fbd_pkg.sv
design/fbd_div.sv
design/fractional_baud_divisor_search.sv
sim/tb_fractional_baud_divisor_search.sv
